>>> rtl/core/dest_pkg.sv
// Package for the deadline event slot table: sizes, operation codes and result kinds.
package dest_pkg;

  // Table size and the widths that follow from it.
  localparam int NUM_SLOTS   = 16;
  localparam int MAX_RESULTS = 16;
  localparam int SLOT_W      = $clog2(NUM_SLOTS);
  localparam int CNT_W       = SLOT_W + 1;

  // Field widths of the words on both channels.
  localparam int DEC_W  = 16;
  localparam int TMO_W  = 16;
  localparam int SLOT_F = 4;
  localparam int TIME_W = 32;
  localparam int IN_W   = 40;
  localparam int OUT_W  = 24;

  // Operation codes of an input word.
  typedef enum logic [1:0] {
    OP_SCHEDULE = 2'd0,
    OP_UPDATE   = 2'd1,
    OP_QUERY    = 2'd2,
    OP_TICK     = 2'd3
  } op_t;

  // Kinds of a result word.
  typedef enum logic [1:0] {
    KIND_ALLOC = 2'd0,
    KIND_QUERY = 2'd1,
    KIND_FIRE  = 2'd2
  } kind_t;

  // Sequencer states, one-hot.
  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_QRD   = 4'b0010,
    ST_SCAN  = 4'b0100,
    ST_FLUSH = 4'b1000
  } state_t;

endpackage

>>> rtl/core/deadline_event_slot_table_core.sv
// Deadline event slot table: slot memories, time counter, tick scanner and result register.
//
//  channel | direction | tvalid/tready | tdata (low bit up)                  | tuser  | tlast
//  s_      | in        | handshake     | decision_in, timeout, slot_in, pad  | opcode | -
//  m_      | out       | handshake     | slot_out, decision_out, pad         | kind   | last
//
// Schedule and update are handled in idle; a query reads the slot memory before its result is loaded.
// A tick passes through the accept in idle, then one slot read a cycle from the decision
// and deadline memories while the scanner is not stalled, the read wait, a drain and a flush step.
// Reset clears the time counter, ring pointer, armed bits and control; memories keep contents.
// A stalled result register stalls the scanner only when a second firing is waiting.
module deadline_event_slot_table_core
  import dest_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             s_tvalid,
  output logic             s_tready,
  input  logic [IN_W-1:0]  s_tdata,   // decision_in[15:0], timeout[31:16], slot_in[35:32], zeros
  input  logic [1:0]       s_tuser,   // opcode[1:0]
  output logic             m_tvalid,
  input  logic             m_tready,
  output logic [OUT_W-1:0] m_tdata,   // slot_out[3:0], decision_out[19:4], zeros
  output logic [1:0]       m_tuser,   // kind[1:0]
  output logic             m_tlast
);

  // Input word fields.
  logic [DEC_W-1:0]  in_dec;
  logic [TMO_W-1:0]  in_tmo;
  logic [SLOT_F-1:0] in_slot;
  op_t               in_op;
  logic              in_acc;
  logic              slot_ok;

  assign in_dec  = s_tdata[15:0];
  assign in_tmo  = s_tdata[31:16];
  assign in_slot = s_tdata[35:32];
  assign in_op   = op_t'(s_tuser);
  assign in_acc  = s_tvalid && s_tready;
  assign slot_ok = (32'(in_slot) < NUM_SLOTS);

  // Control state.
  state_t              state, state_next;
  logic [TIME_W-1:0]   now_count;
  logic [SLOT_W-1:0]   next_slot;
  logic [NUM_SLOTS-1:0] armed;
  logic [CNT_W-1:0]    issue_cnt;
  logic                dv;
  logic [SLOT_W-1:0]   dv_idx;
  logic                pend_v;
  logic [SLOT_W-1:0]   pend_slot;
  logic [DEC_W-1:0]    pend_dec;
  logic                q_ok;
  logic [SLOT_F-1:0]   q_slot;

  // Result register.
  logic              out_valid;
  logic [1:0]        out_kind;
  logic [SLOT_F-1:0] out_slot;
  logic [DEC_W-1:0]  out_dec;
  logic              out_last;
  logic              out_free;
  logic              out_load;

  assign out_free = !out_valid || m_tready;

  // Slot memories with one registered read port each.
  logic [DEC_W-1:0]  dec_mem [NUM_SLOTS];
  logic [TIME_W-1:0] dl_mem  [NUM_SLOTS];
  logic [DEC_W-1:0]  rd_dec;
  logic [TIME_W-1:0] rd_dl;
  logic              rd_en;
  logic [SLOT_W-1:0] rd_addr;
  logic              dec_we;
  logic [SLOT_W-1:0] dec_waddr;
  logic              dl_we;

  // Scan compare: wrap-safe signed difference of now and deadline.
  logic [TIME_W-1:0] diff;
  logic              hit;
  logic              scan_adv;
  logic              issue_done;

  assign diff       = now_count - rd_dl;
  assign hit        = dv && armed[dv_idx] && (diff != '0) && !diff[TIME_W-1];
  assign scan_adv   = !(hit && pend_v && !out_free);
  assign issue_done = (issue_cnt == CNT_W'(NUM_SLOTS));

  // The result register takes a new word in this cycle.
  assign out_load = ((state == ST_IDLE) && in_acc && (in_op == OP_SCHEDULE)) ||
                    ((state == ST_QRD) && out_free) ||
                    ((state == ST_SCAN) && scan_adv && hit && pend_v) ||
                    ((state == ST_FLUSH) && pend_v && out_free);

  assign s_tready = (state == ST_IDLE) && out_free;

  // Memory port selection.
  always_comb begin
    rd_en     = 1'b0;
    rd_addr   = issue_cnt[SLOT_W-1:0];
    dec_we    = 1'b0;
    dec_waddr = next_slot;
    dl_we     = 1'b0;
    if (state == ST_IDLE && in_acc) begin
      case (in_op)
        OP_SCHEDULE: begin
          dec_we = 1'b1;
          dl_we  = 1'b1;
        end
        OP_UPDATE: begin
          dec_we    = slot_ok;
          dec_waddr = SLOT_W'(in_slot);
        end
        OP_QUERY: begin
          rd_en   = 1'b1;
          rd_addr = SLOT_W'(in_slot);
        end
        default: ;
      endcase
    end else if (state == ST_SCAN && scan_adv && !issue_done) begin
      rd_en = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (dec_we) dec_mem[dec_waddr] <= in_dec;
    if (dl_we) dl_mem[next_slot] <= now_count + TIME_W'(in_tmo);
    if (rd_en) begin
      rd_dec <= dec_mem[rd_addr];
      rd_dl  <= dl_mem[rd_addr];
    end
  end

  // Next-state logic of the sequencer.
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_acc && in_op == OP_QUERY) state_next = ST_QRD;
        else if (in_acc && in_op == OP_TICK) state_next = ST_SCAN;
      end
      ST_QRD: begin
        if (out_free) state_next = ST_IDLE;
      end
      ST_SCAN: begin
        if (issue_done && !dv) state_next = ST_FLUSH;
      end
      ST_FLUSH: begin
        if (!pend_v || out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Control registers, scanner and result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      now_count <= '0;
      next_slot <= '0;
      armed     <= '0;
      issue_cnt <= '0;
      dv        <= 1'b0;
      pend_v    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (out_valid && m_tready && !out_load) out_valid <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (in_acc) begin
            q_ok   <= slot_ok;
            q_slot <= in_slot;
            case (in_op)
              OP_SCHEDULE: begin
                armed[next_slot] <= 1'b1;
                next_slot <= (32'(next_slot) == NUM_SLOTS - 1) ? '0 : next_slot + 1'b1;
                out_valid <= 1'b1;
                out_kind  <= KIND_ALLOC;
                out_slot  <= SLOT_F'(next_slot);
                out_dec   <= '0;
                out_last  <= 1'b1;
              end
              OP_TICK: begin
                now_count <= now_count + 1'b1;
                issue_cnt <= '0;
                dv        <= 1'b0;
                pend_v    <= 1'b0;
              end
              default: ;
            endcase
          end
        end
        ST_QRD: begin
          if (out_free) begin
            out_valid <= 1'b1;
            out_kind  <= KIND_QUERY;
            out_slot  <= q_slot;
            out_dec   <= q_ok ? rd_dec : '0;
            out_last  <= 1'b1;
          end
        end
        ST_SCAN: begin
          if (scan_adv) begin
            // Issue the next read, or let the pipeline drain.
            if (!issue_done) begin
              dv        <= 1'b1;
              dv_idx    <= issue_cnt[SLOT_W-1:0];
              issue_cnt <= issue_cnt + 1'b1;
            end else begin
              dv <= 1'b0;
            end
            // A new firing pushes the held one out; only the final one gets last.
            if (hit) begin
              armed[dv_idx] <= 1'b0;
              pend_v    <= 1'b1;
              pend_slot <= dv_idx;
              pend_dec  <= rd_dec;
              if (pend_v) begin
                out_valid <= 1'b1;
                out_kind  <= KIND_FIRE;
                out_slot  <= SLOT_F'(pend_slot);
                out_dec   <= pend_dec;
                out_last  <= 1'b0;
              end
            end
          end
        end
        ST_FLUSH: begin
          if (pend_v && out_free) begin
            pend_v    <= 1'b0;
            out_valid <= 1'b1;
            out_kind  <= KIND_FIRE;
            out_slot  <= SLOT_F'(pend_slot);
            out_dec   <= pend_dec;
            out_last  <= 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {4'b0000, out_dec, out_slot};
  assign m_tuser  = out_kind;
  assign m_tlast  = out_last;

`ifndef NO_ASSERTIONS
  // The sequencer stays one-hot.
  a_state_onehot: assert property (@(posedge clk) disable iff (rst) $onehot(state))
    else $error("sequencer state is not one-hot");

  // Input is taken only while the sequencer is idle.
  a_ready_idle: assert property (@(posedge clk) disable iff (rst)
    s_tready |-> (state == ST_IDLE))
    else $error("input accepted outside idle");

  // A tick advances time by exactly one.
  a_tick_time: assert property (@(posedge clk) disable iff (rst)
    (in_acc && in_op == OP_TICK) |=> (now_count == $past(now_count) + 1'b1))
    else $error("tick did not advance time by one");

  // A schedule shows its allocation result in the next cycle.
  a_sched_out: assert property (@(posedge clk) disable iff (rst)
    (in_acc && in_op == OP_SCHEDULE) |=>
      (out_valid && out_kind == KIND_ALLOC && out_last))
    else $error("schedule result missing");

  // A slot that fires is disarmed.
  a_fire_disarm: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SCAN && scan_adv && hit) |=> !armed[$past(dv_idx)])
    else $error("fired slot still armed");
`endif

endmodule

>>> sim/tb_deadline_event_slot_table_core.sv
// Self-checking testbench for the deadline event slot table core.
`timescale 1ns / 100ps

module tb_deadline_event_slot_table_core;
  import dest_pkg::*;

  // One result word as seen on the master side.
  typedef struct {
    kind_t             kind;
    logic [SLOT_F-1:0] slot;
    logic [DEC_W-1:0]  dec;
    logic              last;
  } slot_result_t;

  // Tracks the slot table and holds the results that are still owed by the block.
  class slot_table_scoreboard;
    bit [TIME_W-1:0] now_cnt;
    bit [SLOT_F-1:0] ring_ptr;
    bit [DEC_W-1:0]  dec_mem [NUM_SLOTS];
    bit [TIME_W-1:0] deadline_mem [NUM_SLOTS];
    bit              armed [NUM_SLOTS];
    bit              written [NUM_SLOTS];
    slot_result_t    owed_q [$];
    int              errors;

    function void reset_state();
      now_cnt  = '0;
      ring_ptr = '0;
      errors   = 0;
      for (int i = 0; i < NUM_SLOTS; i++) begin
        dec_mem[i]      = '0;
        deadline_mem[i] = '0;
        armed[i]        = 1'b0;
        written[i]      = 1'b0;
      end
    endfunction

    // A slot has expired once now minus deadline, read as signed, is above zero.
    function bit is_expired(bit [TIME_W-1:0] deadline);
      bit [TIME_W-1:0] diff;
      diff = now_cnt - deadline;
      return (diff != '0) && !diff[TIME_W-1];
    endfunction

    // Apply one accepted input word and queue the results it causes.
    function void note_input(op_t op, bit [DEC_W-1:0] dec, bit [TMO_W-1:0] tmo,
                             bit [SLOT_F-1:0] slot);
      slot_result_t r;
      slot_result_t fired [$];
      int s;
      case (op)
        OP_SCHEDULE: begin
          s = int'(ring_ptr);
          dec_mem[s]      = dec;
          deadline_mem[s] = now_cnt + TIME_W'(tmo);
          armed[s]        = 1'b1;
          written[s]      = 1'b1;
          ring_ptr        = SLOT_F'((s + 1) % NUM_SLOTS);
          r = '{KIND_ALLOC, s[SLOT_F-1:0], '0, 1'b1};
          owed_q.push_back(r);
        end
        OP_UPDATE: begin
          if (slot < NUM_SLOTS) begin
            dec_mem[slot] = dec;
            written[slot] = 1'b1;
          end
        end
        OP_QUERY: begin
          r = '{KIND_QUERY, slot, (slot < NUM_SLOTS) ? dec_mem[slot] : '0, 1'b1};
          owed_q.push_back(r);
        end
        default: begin
          now_cnt = now_cnt + 1'b1;
          for (int i = 0; i < NUM_SLOTS && fired.size() < MAX_RESULTS; i++) begin
            if (armed[i] && is_expired(deadline_mem[i])) begin
              r = '{KIND_FIRE, i[SLOT_F-1:0], dec_mem[i], 1'b0};
              fired.push_back(r);
              armed[i] = 1'b0;
            end
          end
          if (fired.size() > 0) fired[fired.size()-1].last = 1'b1;
          foreach (fired[i]) owed_q.push_back(fired[i]);
        end
      endcase
    endfunction

    // Compare one accepted result word with the oldest owed result.
    function void check_result(slot_result_t got);
      slot_result_t want;
      string        want_s;
      string        got_s;
      if (owed_q.size() == 0) begin
        $display("%0t: unexpected result kind %0d slot %0d decision %h last %b",
                 $time, got.kind, got.slot, got.dec, got.last);
        errors++;
        return;
      end
      want = owed_q.pop_front();
      if (got.kind !== want.kind || got.slot !== want.slot ||
          got.dec !== want.dec || got.last !== want.last) begin
        want_s = $sformatf("kind %0d slot %0d decision %h last %b",
                           want.kind, want.slot, want.dec, want.last);
        got_s  = $sformatf("kind %0d slot %0d decision %h last %b",
                           got.kind, got.slot, got.dec, got.last);
        $display("%0t: mismatch expected %s, got %s", $time, want_s, got_s);
        errors++;
      end
    endfunction
  endclass

  logic             clk;
  logic             rst;
  logic             s_tvalid;
  logic             s_tready;
  logic [IN_W-1:0]  s_tdata;   // decision_in[15:0], timeout[31:16], slot_in[35:32], zeros
  logic [1:0]       s_tuser;   // opcode[1:0]
  logic             m_tvalid;
  logic             m_tready;
  logic [OUT_W-1:0] m_tdata;   // slot_out[3:0], decision_out[19:4], zeros
  logic [1:0]       m_tuser;   // kind[1:0]
  logic             m_tlast;

  slot_table_scoreboard sb;
  bit quiet;

  deadline_event_slot_table_core dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  // Clock with a 12 ns period.
  initial clk = 1'b0;
  always #6 clk = ~clk;

  // Hard stop in case the block hangs.
  initial begin
    #5_000_000;
    $display("** deadline_event_slot_table_core: FAILED **");
    $finish;
  end

  // Result sink: random stall bursts until the quiet part of the run.
  initial begin
    int stall;
    stall    = 0;
    m_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (stall > 0) begin
        m_tready <= 1'b0;
        stall--;
      end else if (!quiet && $urandom_range(0, 4) == 0) begin
        m_tready <= 1'b0;
        stall = $urandom_range(1, 4) - 1;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  // Result monitor.
  always @(posedge clk) begin
    slot_result_t got;
    if (!rst && m_tvalid && m_tready) begin
      got.kind = kind_t'(m_tuser);
      got.slot = m_tdata[SLOT_F-1:0];
      got.dec  = m_tdata[SLOT_F +: DEC_W];
      got.last = m_tlast;
      sb.check_result(got);
    end
  end

  // Drive one input word, with an optional idle burst ahead of it.
  task automatic send_word(op_t op, bit [DEC_W-1:0] dec, bit [TMO_W-1:0] tmo,
                           bit [SLOT_F-1:0] slot);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= {{(IN_W-SLOT_F-TMO_W-DEC_W){1'b0}}, slot, tmo, dec};
    do @(posedge clk); while (!(s_tvalid && s_tready));
    sb.note_input(op, dec, tmo, slot);
    @(negedge clk);
  endtask

  // Pick a slot that has been written, so a query never reads stale memory.
  function automatic bit [SLOT_F-1:0] pick_written_slot();
    bit [SLOT_F-1:0] s;
    s = SLOT_F'($urandom_range(0, NUM_SLOTS-1));
    while (!sb.written[s]) s = s + 1'b1;
    return s;
  endfunction

  // Random mix weighted toward schedules and ticks so slots keep firing.
  task automatic run_random(int count);
    int pick;
    bit [TMO_W-1:0] tmo;
    for (int n = 0; n < count; n++) begin
      pick = $urandom_range(0, 99);
      if ($urandom_range(0, 9) == 0) tmo = TMO_W'($urandom);
      else tmo = TMO_W'($urandom_range(0, 12));
      if (pick < 30)
        send_word(OP_SCHEDULE, DEC_W'($urandom), tmo, SLOT_F'($urandom));
      else if (pick < 45)
        send_word(OP_UPDATE, DEC_W'($urandom), TMO_W'($urandom), SLOT_F'($urandom));
      else if (pick < 65)
        send_word(OP_QUERY, DEC_W'($urandom), TMO_W'($urandom), pick_written_slot());
      else
        send_word(OP_TICK, DEC_W'($urandom), TMO_W'($urandom), SLOT_F'($urandom));
    end
  endtask

  // Main sequence.
  initial begin
    sb = new();
    sb.reset_state();
    quiet    = 1'b0;
    rst      = 1'b1;
    s_tvalid = 1'b0;
    s_tdata  = '0;
    s_tuser  = OP_SCHEDULE;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed: field extremes, update and read back, zero timeout firing next tick.
    send_word(OP_SCHEDULE, 16'hFFFF, 16'h0000, 4'h0);
    send_word(OP_QUERY, 16'h0000, 16'h0000, 4'h0);
    send_word(OP_UPDATE, 16'h0000, 16'hFFFF, 4'h0);
    send_word(OP_QUERY, 16'hFFFF, 16'hFFFF, 4'h0);
    send_word(OP_TICK, 16'hFFFF, 16'hFFFF, 4'hF);
    // Longest timeout: stays armed far beyond the run.
    send_word(OP_SCHEDULE, 16'hA5A5, 16'hFFFF, 4'hF);
    // Update of a slot that was never scheduled, then read it back.
    send_word(OP_UPDATE, 16'h1234, 16'h0000, 4'hF);
    send_word(OP_QUERY, 16'h0000, 16'h0000, 4'hF);
    // Fill the rest of the ring, wrap the pointer, then fire all slots on one tick.
    for (int i = 2; i < NUM_SLOTS + 2; i++)
      send_word(OP_SCHEDULE, DEC_W'($urandom), 16'h0000, SLOT_F'($urandom));
    send_word(OP_TICK, 16'h0000, 16'h0000, 4'h0);

    // Random part; the last stretch runs with no idling on either side.
    run_random(325);
    quiet = 1'b1;
    run_random(80);

    s_tvalid <= 1'b0;
    while (sb.owed_q.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);

    if (sb.errors == 0 && sb.owed_q.size() == 0) begin
      $display("** deadline_event_slot_table_core: PASSED **");
    end else begin
      $display("** deadline_event_slot_table_core: FAILED **");
    end
    $finish;
  end

endmodule
